// File: rtl/csc_pkg.sv
// Package for the compact size codec: command and result codes, prefix
// constants, field lengths and the queue entry and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;

	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	localparam logic KIND_DECODED = 1'b0;
	localparam logic KIND_ENCODED = 1'b1;

	localparam logic [7:0] MAX_DIRECT = 8'hFC;
	localparam logic [7:0] PREFIX_16  = 8'hFD;
	localparam logic [7:0] PREFIX_32  = 8'hFE;
	localparam logic [7:0] PREFIX_64  = 8'hFF;

	// total field lengths announced by each prefix
	localparam logic [3:0] LEN_16 = 4'd3;
	localparam logic [3:0] LEN_32 = 4'd5;
	localparam logic [3:0] LEN_64 = 4'd9;

	localparam int QUEUE_DEPTH = 2;

	// one classified item as it waits between front and back
	typedef struct packed {
		logic        command;
		logic [7:0]  in_byte;
		logic        end_of_data;
		logic [63:0] plain_value;
		logic [3:0]  payload_len;  // 0 for a one-byte form, else 2, 4 or 8
		logic [7:0]  first_byte;   // prefix, or the value itself when short
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// File: rtl/csc_front.sv
// Front end of the compact size codec: accepts input transfers, classifies
// encode values by form length and pushes them into the queue.
// Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 command,
	input  wire  [7:0]          in_byte,
	input  wire                 end_of_data,
	input  wire  [63:0]         plain_value,
	input  csc_pkg::queue_status_t q_status,
	output logic                push,
	output csc_pkg::item_t      push_item
);

	logic           valid_s1;
	csc_pkg::item_t item_s1;
	csc_pkg::item_t item_c;
	logic           ready;
	logic           take;

	always_comb begin
		item_c.command     = command;
		item_c.in_byte     = in_byte;
		item_c.end_of_data = end_of_data;
		item_c.plain_value = plain_value;
		if (|plain_value[63:32]) begin
			item_c.payload_len = 4'd8;
			item_c.first_byte  = csc_pkg::PREFIX_64;
		end else if (|plain_value[31:16]) begin
			item_c.payload_len = 4'd4;
			item_c.first_byte  = csc_pkg::PREFIX_32;
		end else if ((|plain_value[15:8]) || (plain_value[7:0] > csc_pkg::MAX_DIRECT)) begin
			item_c.payload_len = 4'd2;
			item_c.first_byte  = csc_pkg::PREFIX_16;
		end else begin
			item_c.payload_len = 4'd0;
			item_c.first_byte  = plain_value[7:0];
		end
	end

	assign push      = valid_s1 && !q_status.full;
	assign ready     = !valid_s1 || !q_status.full;
	assign take      = in_valid && ready;
	assign in_stall  = !ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

// File: rtl/csc_queue.sv
// Short register queue between front and back of the compact size codec.
// Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csc_queue #(
	parameter int DEPTH = csc_pkg::QUEUE_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  csc_pkg::item_t         push_item,
	input  wire                    pop,
	output csc_pkg::item_t         head,
	output csc_pkg::queue_status_t status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	csc_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: rtl/csc_back.sv
// Back end of the compact size codec: streaming decoder state, the encode
// byte sequencer and the output register.
// Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csc_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  csc_pkg::item_t         head,
	input  csc_pkg::queue_status_t q_status,
	output logic                   pop,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   kind,
	output logic [63:0]            decoded_value,
	output logic [3:0]             consumed,
	output logic                   truncated,
	output logic [7:0]             enc_byte,
	output logic                   last
);

	// decoder state
	logic [3:0]  seen_q;
	logic [3:0]  need_q;
	logic [63:0] acc_q;
	// encoder sequencer
	logic        enc_active_q;
	logic [63:0] enc_val_q;
	logic [3:0]  enc_rem_q;
	// output register
	logic        ov_q;
	logic        kind_q;
	logic [63:0] value_q;
	logic [3:0]  consumed_q;
	logic        trunc_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        can_load;
	logic        start;
	logic        is_enc;
	logic [3:0]  seen_n;
	logic [2:0]  lane;
	logic [63:0] acc_n;
	logic        dec_res;
	logic [63:0] dec_val;
	logic [3:0]  dec_cons;
	logic        dec_trunc;
	logic        dec_idle;

	assign can_load = !ov_q || !out_stall;
	assign start    = can_load && !enc_active_q && !q_status.empty;
	assign pop      = start;
	assign is_enc   = (head.command == csc_pkg::CMD_ENCODE);
	assign seen_n   = 4'(seen_q + 4'd1);
	assign lane     = 3'(seen_q - 4'd1);

	always_comb begin
		acc_n = acc_q;
		for (int i = 0; i < 8; i++) begin
			if (lane == 3'(i)) begin
				acc_n[8*i +: 8] = head.in_byte;
			end
		end
	end

	always_comb begin
		dec_res   = 1'b0;
		dec_val   = '0;
		dec_cons  = '0;
		dec_trunc = 1'b0;
		dec_idle  = 1'b0;
		if (seen_q == 4'd0) begin
			if (head.in_byte <= csc_pkg::MAX_DIRECT) begin
				dec_res  = 1'b1;
				dec_val  = {56'd0, head.in_byte};
				dec_cons = 4'd1;
				dec_idle = 1'b1;
			end else if (head.end_of_data) begin
				dec_res   = 1'b1;
				dec_cons  = 4'd1;
				dec_trunc = 1'b1;
				dec_idle  = 1'b1;
			end
		end else if (seen_n >= need_q) begin
			dec_res  = 1'b1;
			dec_val  = acc_n;
			dec_cons = need_q;
			dec_idle = 1'b1;
		end else if (head.end_of_data) begin
			dec_res   = 1'b1;
			dec_cons  = seen_n;
			dec_trunc = 1'b1;
			dec_idle  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			need_q       <= '0;
			acc_q        <= '0;
			enc_active_q <= 1'b0;
			enc_rem_q    <= '0;
			ov_q         <= 1'b0;
		end else if (can_load) begin
			if (enc_active_q) begin
				ov_q      <= 1'b1;
				enc_rem_q <= 4'(enc_rem_q - 4'd1);
				if (enc_rem_q == 4'd1) begin
					enc_active_q <= 1'b0;
				end
			end else if (start) begin
				if (is_enc) begin
					ov_q <= 1'b1;
					if (head.payload_len != 4'd0) begin
						enc_active_q <= 1'b1;
						enc_rem_q    <= head.payload_len;
					end
				end else begin
					ov_q <= dec_res;
					if (dec_idle) begin
						seen_q <= '0;
						need_q <= '0;
						acc_q  <= '0;
					end else if (seen_q == 4'd0) begin
						seen_q <= 4'd1;
						acc_q  <= '0;
						if (head.in_byte == csc_pkg::PREFIX_16) begin
							need_q <= csc_pkg::LEN_16;
						end else if (head.in_byte == csc_pkg::PREFIX_32) begin
							need_q <= csc_pkg::LEN_32;
						end else begin
							need_q <= csc_pkg::LEN_64;
						end
					end else begin
						seen_q <= seen_n;
						acc_q  <= acc_n;
					end
				end
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload side of the output register and encoder shift register
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (enc_active_q) begin
				kind_q     <= csc_pkg::KIND_ENCODED;
				value_q    <= '0;
				consumed_q <= '0;
				trunc_q    <= 1'b0;
				byte_q     <= enc_val_q[7:0];
				last_q     <= (enc_rem_q == 4'd1);
				enc_val_q  <= {8'd0, enc_val_q[63:8]};
			end else if (start) begin
				if (is_enc) begin
					kind_q     <= csc_pkg::KIND_ENCODED;
					value_q    <= '0;
					consumed_q <= '0;
					trunc_q    <= 1'b0;
					byte_q     <= head.first_byte;
					last_q     <= (head.payload_len == 4'd0);
					enc_val_q  <= head.plain_value;
				end else begin
					kind_q     <= csc_pkg::KIND_DECODED;
					value_q    <= dec_val;
					consumed_q <= dec_cons;
					trunc_q    <= dec_trunc;
					byte_q     <= '0;
					last_q     <= 1'b1;
				end
			end
		end
	end

	assign out_valid     = ov_q;
	assign kind          = kind_q;
	assign decoded_value = value_q;
	assign consumed      = consumed_q;
	assign truncated     = trunc_q;
	assign enc_byte      = byte_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// File: rtl/compact_size_codec.sv
// Top level of the compact size codec: front end, queue and back end.
// Depends on csc_pkg, csc_front, csc_queue and csc_back.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid, in_stall | command, in_byte, end_of_data, plain_value
//   output  | out_valid,out_stall| kind, decoded_value, consumed, truncated,
//           |                    | enc_byte, last
//
// A decode item gives at most one result; an encode item holds the back end
// while it gives 1, 3, 5 or 9 bytes, one byte a cycle unless out_stall holds
// the output. From input transfer to first result an item passes the front
// stage, the queue and the output register. Reset on arst_n clears the decoder
// to idle and empties the queue. Output stall holds the back end; the queue
// then fills and the front stalls the input on its own.
`timescale 1ns / 1ps
`default_nettype none
module compact_size_codec #(
	parameter int QUEUE_DEPTH = csc_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         command,
	input  wire  [7:0]  in_byte,
	input  wire         end_of_data,
	input  wire  [63:0] plain_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        kind,
	output logic [63:0] decoded_value,
	output logic [3:0]  consumed,
	output logic        truncated,
	output logic [7:0]  enc_byte,
	output logic        last
);

	csc_pkg::queue_status_t q_status;
	csc_pkg::item_t         push_item;
	csc_pkg::item_t         head;
	logic                   push;
	logic                   pop;

	csc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.in_byte    (in_byte),
		.end_of_data(end_of_data),
		.plain_value(plain_value),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	csc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	csc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.decoded_value(decoded_value),
		.consumed     (consumed),
		.truncated    (truncated),
		.enc_byte     (enc_byte),
		.last         (last)
	);

endmodule
`default_nettype wire
